/* rtl/tlpq_pkg.sv */
// ----------------------------------------------------------------------------
// tlpq_pkg
// Shared codes and types for the three-level priority queue.
// ----------------------------------------------------------------------------
`default_nettype none

package tlpq_pkg;

  localparam int unsigned NumClasses = 3;
  localparam int unsigned ItemTagW   = 16;

  // command codes
  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_SERVE  = 1'b1;

  // class codes
  localparam logic [1:0] CLS_CANCEL = 2'd0;
  localparam logic [1:0] CLS_NONE   = 2'd0;
  localparam logic [1:0] CLS_EMERG  = 2'd1;
  localparam logic [1:0] CLS_URGENT = 2'd2;
  localparam logic [1:0] CLS_NORMAL = 2'd3;

  // result status codes
  localparam logic [2:0] ST_INSERTED = 3'd0;
  localparam logic [2:0] ST_SERVED   = 3'd1;
  localparam logic [2:0] ST_EMPTY    = 3'd2;
  localparam logic [2:0] ST_FULL     = 3'd3;
  localparam logic [2:0] ST_CANCEL   = 3'd4;

  typedef struct packed {
    logic [2:0] status;
    logic [1:0] served_class;
  } result_t;

  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } mem_ctl_t;

endpackage

`default_nettype wire

/* rtl/tlpq_req_if.sv */
// ----------------------------------------------------------------------------
// tlpq_req_if
// Command channel: insert or serve requests with class and tag.
// ----------------------------------------------------------------------------
`default_nettype none

interface tlpq_req_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [1:0]  class_level;
  logic [15:0] item_tag;

  modport source (output valid, output command, output class_level, output item_tag,
                  input ready);
  modport sink   (input valid, input command, input class_level, input item_tag,
                  output ready);
endinterface

`default_nettype wire

/* rtl/tlpq_rsp_if.sv */
// ----------------------------------------------------------------------------
// tlpq_rsp_if
// Result channel: status, served tag and served class.
// ----------------------------------------------------------------------------
`default_nettype none

interface tlpq_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [15:0] served_tag;
  logic [1:0]  served_class;

  modport source (output valid, output status, output served_tag, output served_class,
                  input ready);
  modport sink   (input valid, input status, input served_tag, input served_class,
                  output ready);
endinterface

`default_nettype wire

/* rtl/three_level_priority_queue.sv */
// ----------------------------------------------------------------------------
// three_level_priority_queue
// Strict-priority queue of item tags in three FIFO classes.
// ----------------------------------------------------------------------------
// Usage:
//   req_i carries one command per item: insert (class 1 emergency, 2 urgent,
//   3 non-urgent, 0 cancel) with a tag, or serve. rsp_o returns exactly one
//   result per item: inserted, served (with tag and class), all empty,
//   class full (dropped) or cancelled.
//   Each class owns CLASS_DEPTH slots of a single tag memory; head, tail and
//   count per class sit in flip-flops, so an item is decided in the cycle it
//   is accepted and a serve reads the memory once.
//   A result passes from the memory read stage into the output register
//   before it shows on rsp_o.
//   Throughput: one item per cycle unless rsp_o stalls, set by the single
//   memory port; req_i keeps taking items while a result waits in the output
//   register, and holds ready low only when both stages are occupied.
//   Reset empties all three classes at once; no clearing pass is needed.
//   A stalled receiver holds the result on rsp_o; the stage behind it fills
//   and then req_i.ready drops until rsp_o.ready returns.
// ----------------------------------------------------------------------------
`default_nettype none

module three_level_priority_queue #(
  parameter int unsigned CLASS_DEPTH = 16,
  parameter int unsigned TAG_BITS    = 16
) (
  input  wire       clk_i,
  input  wire       rst_ni,
  tlpq_req_if.sink  req_i,
  tlpq_rsp_if.source rsp_o
);
  import tlpq_pkg::*;

  localparam int unsigned Depth = NumClasses * CLASS_DEPTH;
  localparam int unsigned AddrW = $clog2(Depth);

  mem_ctl_t          mem_ctl;
  logic [AddrW-1:0]  mem_addr;
  logic [15:0]       rd_tag;
  result_t           res;

  logic              accept;
  logic              s1_move;
  logic              s1_valid_q;
  result_t           s1_res_q;

  logic              out_valid_q;
  logic [2:0]        out_status_q;
  logic [15:0]       out_tag_q;
  logic [1:0]        out_class_q;

  assign s1_move     = s1_valid_q && (!out_valid_q || rsp_o.ready);
  assign req_i.ready = !s1_valid_q || s1_move;
  assign accept      = req_i.valid && req_i.ready;

  tlpq_ctrl #(
    .ClassDepth (CLASS_DEPTH),
    .AddrW      (AddrW)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .command_i     (req_i.command),
    .class_level_i (req_i.class_level),
    .mem_ctl_o     (mem_ctl),
    .mem_addr_o    (mem_addr),
    .result_o      (res)
  );

  tlpq_mem #(
    .Depth   (Depth),
    .TagBits (TAG_BITS),
    .AddrW   (AddrW)
  ) u_mem (
    .clk_i    (clk_i),
    .ctl_i    (mem_ctl),
    .addr_i   (mem_addr),
    .wr_tag_i (req_i.item_tag),
    .rd_tag_o (rd_tag)
  );

  // stage 1 waits on the memory read; read data holds while it stalls
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid_q <= 1'b1;
      end else if (s1_move) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_move) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_res_q <= res;
    end
    if (s1_move) begin
      out_status_q <= s1_res_q.status;
      out_class_q  <= s1_res_q.served_class;
      out_tag_q    <= (s1_res_q.status == ST_SERVED) ? rd_tag : '0;
    end
  end

  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.status       = out_status_q;
  assign rsp_o.served_tag   = out_tag_q;
  assign rsp_o.served_class = out_class_q;

endmodule

`default_nettype wire

/* rtl/tlpq_mem.sv */
// ----------------------------------------------------------------------------
// tlpq_mem
// Tag store: one port shared by write and read, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tlpq_mem #(
  parameter int unsigned Depth   = 48,
  parameter int unsigned TagBits = 16,
  parameter int unsigned AddrW   = 6
) (
  input  wire                   clk_i,
  input  tlpq_pkg::mem_ctl_t    ctl_i,
  input  wire  [AddrW-1:0]      addr_i,
  input  wire  [15:0]           wr_tag_i,
  output logic [15:0]           rd_tag_o
);
  import tlpq_pkg::*;

  logic [TagBits-1:0] mem_q [Depth];
  logic [TagBits-1:0] wr_word;
  logic [TagBits-1:0] rd_word_q;

  // fit the 16-bit tag to the stored width and back
  generate
    if (TagBits > ItemTagW) begin : g_wide
      assign wr_word  = {{(TagBits-ItemTagW){1'b0}}, wr_tag_i};
      assign rd_tag_o = rd_word_q[ItemTagW-1:0];
    end else if (TagBits == ItemTagW) begin : g_same
      assign wr_word  = wr_tag_i;
      assign rd_tag_o = rd_word_q;
    end else begin : g_narrow
      assign wr_word  = wr_tag_i[TagBits-1:0];
      assign rd_tag_o = {{(ItemTagW-TagBits){1'b0}}, rd_word_q};
    end
  endgenerate

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      mem_q[addr_i] <= wr_word;
    end
    if (ctl_i.rd_en) begin
      rd_word_q <= mem_q[addr_i];
    end
  end

endmodule

`default_nettype wire

/* rtl/tlpq_ctrl.sv */
// ----------------------------------------------------------------------------
// tlpq_ctrl
// Per-class head, tail and count registers; decides each item's outcome.
// ----------------------------------------------------------------------------
`default_nettype none

module tlpq_ctrl #(
  parameter int unsigned ClassDepth = 16,
  parameter int unsigned AddrW      = 6
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  accept_i,
  input  wire                  command_i,
  input  wire  [1:0]           class_level_i,
  output tlpq_pkg::mem_ctl_t   mem_ctl_o,
  output logic [AddrW-1:0]     mem_addr_o,
  output tlpq_pkg::result_t    result_o
);
  import tlpq_pkg::*;

  localparam int unsigned IdxW = $clog2(ClassDepth);
  localparam int unsigned CntW = $clog2(ClassDepth + 1);
  localparam logic [IdxW-1:0]  IdxLast  = IdxW'(ClassDepth - 1);
  localparam logic [CntW-1:0]  CntFull  = CntW'(ClassDepth);
  localparam logic [AddrW-1:0] RegionSz = AddrW'(ClassDepth);

  logic [IdxW-1:0] head_q [NumClasses];
  logic [IdxW-1:0] head_d [NumClasses];
  logic [IdxW-1:0] tail_q [NumClasses];
  logic [IdxW-1:0] tail_d [NumClasses];
  logic [CntW-1:0] count_q [NumClasses];
  logic [CntW-1:0] count_d [NumClasses];

  logic [1:0]      ins_cls;
  logic [1:0]      srv_cls;
  logic            any_held;

  function automatic logic [IdxW-1:0] next_slot(input logic [IdxW-1:0] idx);
    return (idx == IdxLast) ? '0 : idx + IdxW'(1);
  endfunction

  assign ins_cls = class_level_i - 2'd1;

  // lowest nonempty class wins
  always_comb begin
    srv_cls  = 2'd0;
    any_held = 1'b0;
    for (int i = NumClasses - 1; i >= 0; i--) begin
      if (count_q[i] != '0) begin
        srv_cls  = 2'(i);
        any_held = 1'b1;
      end
    end
  end

  always_comb begin
    for (int i = 0; i < NumClasses; i++) begin
      head_d[i]  = head_q[i];
      tail_d[i]  = tail_q[i];
      count_d[i] = count_q[i];
    end
    mem_ctl_o             = '0;
    mem_addr_o            = '0;
    result_o.status       = ST_EMPTY;
    result_o.served_class = CLS_NONE;

    if (command_i == CMD_INSERT) begin
      if (class_level_i == CLS_CANCEL) begin
        result_o.status = ST_CANCEL;
      end else if (count_q[ins_cls] == CntFull) begin
        result_o.status = ST_FULL;
      end else begin
        result_o.status = ST_INSERTED;
        mem_ctl_o.wr_en = accept_i;
        mem_addr_o      = AddrW'(ins_cls) * RegionSz + AddrW'(tail_q[ins_cls]);
        if (accept_i) begin
          tail_d[ins_cls]  = next_slot(tail_q[ins_cls]);
          count_d[ins_cls] = count_q[ins_cls] + CntW'(1);
        end
      end
    end else if (any_held) begin
      result_o.status       = ST_SERVED;
      result_o.served_class = srv_cls + 2'd1;
      mem_ctl_o.rd_en       = accept_i;
      mem_addr_o            = AddrW'(srv_cls) * RegionSz + AddrW'(head_q[srv_cls]);
      if (accept_i) begin
        head_d[srv_cls]  = next_slot(head_q[srv_cls]);
        count_d[srv_cls] = count_q[srv_cls] - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumClasses; i++) begin
        head_q[i]  <= '0;
        tail_q[i]  <= '0;
        count_q[i] <= '0;
      end
    end else begin
      for (int i = 0; i < NumClasses; i++) begin
        head_q[i]  <= head_d[i];
        tail_q[i]  <= tail_d[i];
        count_q[i] <= count_d[i];
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/tlpq_checker.sv */
// ----------------------------------------------------------------------------
// tlpq_port_checks
// Port-level checks on the result channel of the priority queue.
// ----------------------------------------------------------------------------
`default_nettype none

module tlpq_port_checks (
  input wire        clk_i,
  input wire        rst_ni,
  input wire        req_valid_i,
  input wire        req_ready_i,
  input wire        rsp_valid_i,
  input wire        rsp_ready_i,
  input wire [2:0]  rsp_status_i,
  input wire [15:0] rsp_tag_i,
  input wire [1:0]  rsp_class_i
);
  import tlpq_pkg::*;

  // a stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_status_i)
      && $stable(rsp_tag_i) && $stable(rsp_class_i))
    else $error("result changed while stalled");

  // only served items carry a tag or class
  a_zero_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_status_i != ST_SERVED |-> rsp_tag_i == '0 && rsp_class_i == CLS_NONE)
    else $error("tag or class set on a non-served result");

  // a served item names a real class
  a_served_class: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_status_i == ST_SERVED |-> rsp_class_i != CLS_NONE)
    else $error("served result without class");

  // nothing comes out unless an item was accepted before it
  a_no_invent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_valid_i) |-> $past(req_valid_i && req_ready_i, 2)
      || $past(rsp_valid_i, 1) == 1'b0 && $past(req_valid_i && req_ready_i, 3))
    else $error("result without an accepted item");

endmodule

bind three_level_priority_queue tlpq_port_checks u_port_checks (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .req_valid_i  (req_i.valid),
  .req_ready_i  (req_i.ready),
  .rsp_valid_i  (rsp_o.valid),
  .rsp_ready_i  (rsp_o.ready),
  .rsp_status_i (rsp_o.status),
  .rsp_tag_i    (rsp_o.served_tag),
  .rsp_class_i  (rsp_o.served_class)
);

`default_nettype wire
